@@ src/qpht_pkg.sv @@
package qpht_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 32;

  // Field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned CODE_W   = 64;
  localparam int unsigned REST_W   = 53;
  localparam int unsigned SIZE_W   = 6;
  localparam int unsigned COEF_W   = 5;
  localparam int unsigned YEARS_W  = 6;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned CFG_IDX_W = 2;
  // Probe offset width; offsets stay below 2^13 before the bound check stops the walk
  localparam int unsigned OFF_W    = 13;
  localparam int unsigned FRAC_W   = 32;

  // floor(2^64 * (sqrt(5)-1)/2)
  localparam logic [63:0] GOLD_FRAC = 64'h9E37_79B9_7F4A_7C15;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_COEF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_COEF = 2'd2;

  // One table entry as held in the record memory
  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] surname;
    logic [CODE_W-1:0] post;
    logic [REST_W-1:0] rest;
  } rec_t;

  // Top 32 bits of the 64-bit fraction of years * golden ratio
  function automatic logic [FRAC_W-1:0] hash_frac(input logic [YEARS_W-1:0] years);
    logic [63:0] prod;
    prod = 64'(years) * GOLD_FRAC;
    return prod[63:32];
  endfunction

endpackage

@@ src/qpht_in_if.sv @@
interface qpht_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] surname_code;
  logic [63:0] post_code;
  logic [4:0]  birth_day;
  logic [3:0]  birth_month;
  logic [13:0] birth_year;
  logic [5:0]  service_years;
  logic [23:0] salary_amount;

  modport source (
    output valid, func, surname_code, post_code, birth_day, birth_month,
           birth_year, service_years, salary_amount,
    input  ready
  );
  modport sink (
    input  valid, func, surname_code, post_code, birth_day, birth_month,
           birth_year, service_years, salary_amount,
    output ready
  );
endinterface

@@ src/qpht_out_if.sv @@
interface qpht_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [4:0] slot;

  modport source (output valid, status, slot, input ready);
  modport sink (input valid, status, slot, output ready);
endinterface

@@ src/qpht_mem.sv @@
module qpht_mem #(
  parameter int unsigned DEPTH = qpht_pkg::TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  qpht_pkg::rec_t           wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output qpht_pkg::rec_t           rd_data
);
  import qpht_pkg::*;

  rec_t mem [DEPTH];
  rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/qpht_home.sv @@
module qpht_home (
  input  logic                          clk,
  input  logic [qpht_pkg::YEARS_W-1:0]  years,
  input  logic [qpht_pkg::SIZE_W-1:0]   m,
  output logic [qpht_pkg::SIZE_W-1:0]   home
);
  import qpht_pkg::*;

  logic [FRAC_W-1:0]        frac_r;
  logic [FRAC_W+SIZE_W-1:0] prod;
  logic [SIZE_W-1:0]        home_r;

  // stage 1: fraction, stage 2: scale by slots in use
  assign prod = (FRAC_W+SIZE_W)'(frac_r) * (FRAC_W+SIZE_W)'(m);

  always_ff @(posedge clk) begin
    frac_r <= hash_frac(years);
    home_r <= prod[FRAC_W+SIZE_W-1:FRAC_W];
  end

  assign home = home_r;

endmodule

@@ src/quadratic_probe_hash_table_unit.sv @@
// Quadratic-probe hash table of person records held in one record memory.
// Insert/lookup: after accept, a hash step and a home step, then per slot probed one
// memory read and one compare; the walk may also stop on the bound before a read.
// Next item accepted at the edge after the result appears. Clear writes every entry.
// Reset (rst_n low, synchronous): config to size 32 / coefs 1, then a
// clearing pass over every entry during which no item is accepted.
module quadratic_probe_hash_table_unit #(
  parameter int unsigned TABLE_DEPTH = qpht_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  qpht_in_if.sink                           in_ch,
  qpht_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [qpht_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qpht_pkg::SIZE_W-1:0]       cfg_data
);
  import qpht_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  // slots in use saturate at the depth (and at the 6-bit size range)
  localparam int unsigned M_CAP = (TABLE_DEPTH < 63) ? TABLE_DEPTH : 63;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_HASH  = 7'b0000100,
    S_HOME  = 7'b0001000,
    S_PROBE = 7'b0010000,
    S_CHECK = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // config registers
  logic [SIZE_W-1:0] table_size_r;
  logic [COEF_W-1:0] linear_coef_r;
  logic [COEF_W-1:0] square_coef_r;
  logic [SIZE_W-1:0] m;

  // item under work
  logic [FUNC_W-1:0]  func_r, func_nxt;
  logic [CODE_W-1:0]  sur_r, sur_nxt;
  logic [CODE_W-1:0]  post_r, post_nxt;
  logic [REST_W-1:0]  rest_r, rest_nxt;
  logic [YEARS_W-1:0] years_r, years_nxt;

  // probe walk: off = lc*i + sc*i*i, step = lc + sc*(2i+1)
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [OFF_W-1:0]  step_r, step_nxt;
  logic [SIZE_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  addr_r, addr_nxt;
  logic [OFF_W-1:0]  ind;
  logic [SIZE_W-1:0] home;

  logic [IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             boot_r, boot_nxt;

  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;

  // memory port
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  rec_t             mem_wd;
  logic             mem_re;
  logic [IDX_W-1:0] mem_ra;
  rec_t             rd_rec;
  logic             rec_match;
  logic             in_fire;

  assign m = (table_size_r > SIZE_W'(M_CAP)) ? SIZE_W'(M_CAP) : table_size_r;

  qpht_home u_home (
    .clk   (clk),
    .years (years_r),
    .m     (m),
    .home  (home)
  );

  qpht_mem #(.DEPTH(TABLE_DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_en   (mem_re),
    .rd_addr (mem_ra),
    .rd_data (rd_rec)
  );

  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.slot   = out_slot_r;

  assign ind       = OFF_W'(home) + off_r;
  assign rec_match = (rd_rec.surname == sur_r) && (rd_rec.post == post_r) &&
                     (rd_rec.rest == rest_r);

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    sur_nxt        = sur_r;
    post_nxt       = post_r;
    rest_nxt       = rest_r;
    years_nxt      = years_r;
    off_nxt        = off_r;
    step_nxt       = step_r;
    cnt_nxt        = cnt_r;
    addr_nxt       = addr_r;
    clr_cnt_nxt    = clr_cnt_r;
    boot_nxt       = boot_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = '0;
    mem_re         = 1'b0;
    mem_ra         = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          func_nxt  = in_ch.func;
          sur_nxt   = in_ch.surname_code;
          post_nxt  = in_ch.post_code;
          years_nxt = in_ch.service_years;
          rest_nxt  = {in_ch.birth_day, in_ch.birth_month, in_ch.birth_year,
                       in_ch.service_years, in_ch.salary_amount};
          case (in_ch.func)
            FN_CLEAR: begin
              clr_cnt_nxt = '0;
              boot_nxt    = 1'b0;
              state_nxt   = S_CLEAR;
            end
            FN_INSERT, FN_LOOKUP: begin
              state_nxt = S_HASH;
            end
            default: begin
              // unused code: no table change, reported as a miss
              res_status_nxt = ST_MISSING;
              res_slot_nxt   = '0;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
        if (clr_cnt_r == IDX_W'(TABLE_DEPTH - 1)) begin
          res_status_nxt = ST_CLEARED;
          res_slot_nxt   = '0;
          boot_nxt       = 1'b0;
          state_nxt      = boot_r ? S_IDLE : S_DONE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      S_HASH: begin
        state_nxt = S_HOME;
      end
      S_HOME: begin
        off_nxt   = '0;
        step_nxt  = OFF_W'(linear_coef_r) + OFF_W'(square_coef_r);
        cnt_nxt   = '0;
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if ((cnt_r >= m) || (ind >= OFF_W'(m))) begin
          res_status_nxt = (func_r == FN_INSERT) ? ST_DROPPED : ST_MISSING;
          res_slot_nxt   = '0;
          state_nxt      = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_ra    = ind[IDX_W-1:0];
          addr_nxt  = ind[IDX_W-1:0];
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!rd_rec.valid) begin
          if (func_r == FN_INSERT) begin
            mem_we         = 1'b1;
            mem_wa         = addr_r;
            mem_wd         = '{valid: 1'b1, surname: sur_r, post: post_r, rest: rest_r};
            res_status_nxt = ST_INSERTED;
            res_slot_nxt   = SLOT_W'(addr_r);
          end else begin
            res_status_nxt = ST_MISSING;
            res_slot_nxt   = '0;
          end
          state_nxt = S_DONE;
        end else if ((func_r == FN_LOOKUP) && rec_match) begin
          res_status_nxt = ST_FOUND;
          res_slot_nxt   = SLOT_W'(addr_r);
          state_nxt      = S_DONE;
        end else begin
          off_nxt   = off_r + step_r;
          step_nxt  = step_r + OFF_W'({square_coef_r, 1'b0});
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      boot_r        <= 1'b1;
      clr_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
      table_size_r  <= SIZE_W'(32);
      linear_coef_r <= COEF_W'(1);
      square_coef_r <= COEF_W'(1);
    end else begin
      state_r     <= state_nxt;
      boot_r      <= boot_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TABLE_SIZE:  table_size_r  <= cfg_data;
          CFG_LINEAR_COEF: linear_coef_r <= cfg_data[COEF_W-1:0];
          CFG_SQUARE_COEF: square_coef_r <= cfg_data[COEF_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    sur_r        <= sur_nxt;
    post_r       <= post_nxt;
    rest_r       <= rest_nxt;
    years_r      <= years_nxt;
    off_r        <= off_nxt;
    step_r       <= step_nxt;
    cnt_r        <= cnt_nxt;
    addr_r       <= addr_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  // read data is only consumed in the cycle after its read was issued
  a_check_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> $past(state_r == S_PROBE))
    else $error("compare without a preceding memory read");

  // an insert only ever writes over an empty entry
  a_write_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && (state_r == S_CHECK)) |-> (!rd_rec.valid && (func_r == FN_INSERT)))
    else $error("record written over an occupied entry");

  // probes stay inside the slots in use
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |-> (OFF_W'(mem_ra) < OFF_W'(m)))
    else $error("probe outside the slots in use");

  // a result appears only from the done state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result without a finished operation");

endmodule

@@ tb/sv/qpht_tb_pkg.sv @@
package qpht_tb_pkg;
  import qpht_pkg::*;

  localparam int unsigned TB_DEPTH = TABLE_DEPTH_DEF;

  // func value with no operation behind it
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  // One request item as it goes over the input channel
  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [CODE_W-1:0]  surname;
    logic [CODE_W-1:0]  post;
    logic [4:0]         day;
    logic [3:0]         month;
    logic [13:0]        year;
    logic [YEARS_W-1:0] years;
    logic [23:0]        salary;
  } person_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
  } table_reply_t;

  class hash_table_scoreboard;
    logic [SIZE_W-1:0] size_reg;
    logic [COEF_W-1:0] lin_reg;
    logic [COEF_W-1:0] sq_reg;
    bit                occupied    [TB_DEPTH];
    logic [CODE_W-1:0] surname_mem [TB_DEPTH];
    logic [CODE_W-1:0] post_mem    [TB_DEPTH];
    logic [REST_W-1:0] rest_mem    [TB_DEPTH];
    table_reply_t      awaited     [$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       tally       [5];

    function new();
      size_reg = 6'd32;
      lin_reg  = 5'd1;
      sq_reg   = 5'd1;
      foreach (occupied[k]) occupied[k] = 1'b0;
      foreach (tally[k]) tally[k] = 0;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
      case (idx)
        CFG_TABLE_SIZE:  size_reg = data;
        CFG_LINEAR_COEF: lin_reg  = data[COEF_W-1:0];
        CFG_SQUARE_COEF: sq_reg   = data[COEF_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // Work out the reply to an accepted request and update the table copy
    function void note_request(person_op_t op);
      logic [REST_W-1:0] key_rest;
      logic [63:0]       frac;
      logic [63:0]       scaled;
      int unsigned       m;
      int unsigned       home;
      int unsigned       idx;
      bit                done;
      table_reply_t      r;
      key_rest = {op.day, op.month, op.year, op.years, op.salary};
      m = (size_reg > TB_DEPTH) ? TB_DEPTH : int'(size_reg);
      r.status = ST_MISSING;
      r.slot   = '0;
      case (op.func)
        FN_CLEAR: begin
          foreach (occupied[k]) occupied[k] = 1'b0;
          r.status = ST_CLEARED;
        end
        FN_INSERT, FN_LOOKUP: begin
          frac   = {58'd0, op.years} * GOLD_FRAC;
          scaled = {32'd0, frac[63:32]} * 64'(m);
          home   = scaled[63:32];
          r.status = (op.func == FN_INSERT) ? ST_DROPPED : ST_MISSING;
          done = 1'b0;
          for (int unsigned p = 0; p < m && !done; p++) begin
            idx = home + lin_reg * p + sq_reg * p * p;
            if (idx >= m) begin
              done = 1'b1;
            end else if (!occupied[idx]) begin
              if (op.func == FN_INSERT) begin
                occupied[idx]    = 1'b1;
                surname_mem[idx] = op.surname;
                post_mem[idx]    = op.post;
                rest_mem[idx]    = key_rest;
                r.status = ST_INSERTED;
                r.slot   = SLOT_W'(idx);
              end
              done = 1'b1;
            end else if (op.func == FN_LOOKUP && surname_mem[idx] == op.surname &&
                         post_mem[idx] == op.post && rest_mem[idx] == key_rest) begin
              r.status = ST_FOUND;
              r.slot   = SLOT_W'(idx);
              done = 1'b1;
            end
          end
        end
        default: ;
      endcase
      awaited = {awaited, r};
    endfunction

    function void check_reply(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot);
      table_reply_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: status %0d slot %0d", status, slot);
        errors++;
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (want.status <= ST_MISSING) tally[want.status]++;
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        errors++;
      end
      if (slot !== want.slot) begin
        $error("slot: expected %0d, actual %0d", want.slot, slot);
        errors++;
      end
    endfunction
  endclass

endpackage

@@ tb/sv/tb_top.sv @@
module tb_top;
  import qpht_pkg::*;
  import qpht_tb_pkg::*;

  localparam int unsigned RUN_LIMIT       = 1_000_000;
  localparam int unsigned DRAIN_CYCLES    = 100;   // outlasts a clear operation
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned ITEMS_PER_PHASE = 135;
  localparam int unsigned PHASES          = 9;     // reconfigured phases after the first
  localparam int unsigned STEADY_PHASE    = 4;     // no idling on either side here
  localparam int unsigned IDLE_PCT        = 21;
  localparam int unsigned POOL_MAX        = 40;
  localparam int unsigned PERSON_W        = $bits(person_op_t);

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;
  bit                   steady;
  int unsigned          cycle_count = 0;

  qpht_in_if  in_ch ();
  qpht_out_if out_ch ();

  quadratic_probe_hash_table_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hash_table_scoreboard sb = new();

  // Records inserted lately; lookups draw from here so they actually hit
  person_op_t pool [$];

  // Settings per phase: size 0 and size above depth, zero coefficients,
  // max coefficients, a couple of midrange points; the last one is random.
  int unsigned phase_size [PHASES] = '{1, 0, 63, 32, 7, 17, 32, 2, 0};
  int unsigned phase_lin  [PHASES] = '{0, 5, 31, 0, 3, 2, 31, 1, 0};
  int unsigned phase_sq   [PHASES] = '{1, 1, 31, 0, 2, 1, 31, 0, 1};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side backpressure: ~21% stall per cycle, none in the steady phase
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Result monitor; everything sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_reply(out_ch.status, out_ch.slot);
  end

  function automatic person_op_t as_op(person_op_t p, logic [FUNC_W-1:0] f);
    p.func = f;
    return p;
  endfunction

  // Random record; codes sometimes pinned to all-zero / all-one, month and
  // year sometimes beyond their nominal range (the block still has to cope)
  function automatic person_op_t fresh_person(logic [FUNC_W-1:0] f);
    person_op_t p;
    int unsigned pick;
    p.func = f;
    pick = $urandom_range(0, 9);
    p.surname = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    p.post    = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
    p.day     = 5'($urandom_range(0, 31));
    p.month   = 4'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(0, 12));
    p.year    = 14'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 16383)
                                                 : $urandom_range(0, 9999));
    // half the keys from a narrow set so probe chains get long
    p.years   = 6'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 7)
                                               : $urandom_range(0, 63));
    p.salary  = 24'($urandom_range(0, 24'hFFFFFF));
    return p;
  endfunction

  // Present one item at the falling edge, hold it until accepted.
  // Enters and leaves at a falling edge; valid is left high on purpose.
  task automatic push_item(input person_op_t p);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.func          <= p.func;
    in_ch.surname_code  <= p.surname;
    in_ch.post_code     <= p.post;
    in_ch.birth_day     <= p.day;
    in_ch.birth_month   <= p.month;
    in_ch.birth_year    <= p.year;
    in_ch.service_years <= p.years;
    in_ch.salary_amount <= p.salary;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(p);
    @(negedge clk);
  endtask

  // Block is idle once every result is in; the task still lets it settle before returning
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // One register per cycle; enable only dropped after the last one
  task automatic write_settings(input int unsigned tsize, input int unsigned lin,
                                input int unsigned sq);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [SIZE_W-1:0]    val [3];
    idx = '{CFG_TABLE_SIZE, CFG_LINEAR_COEF, CFG_SQUARE_COEF};
    val = '{SIZE_W'(tsize), SIZE_W'(lin), SIZE_W'(sq)};
    for (int k = 0; k < 3; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      sb.set_reg(idx[k], val[k]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Directed item set at the reset settings (size 32, coefs 1)
  task automatic run_directed();
    person_op_t ones;
    person_op_t zeros;
    person_op_t chain [7];
    ones  = '{FN_INSERT, '1, '1, 5'd31, 4'd12, 14'd9999, 6'd63, 24'hFFFFFF};
    zeros = '{FN_INSERT, '0, '0, 5'd0, 4'd0, 14'd0, 6'd0, 24'd0};
    push_item(as_op(ones, FN_LOOKUP));       // empty table: miss
    push_item(ones);
    push_item(zeros);
    push_item(as_op(ones, FN_LOOKUP));
    push_item(as_op(zeros, FN_LOOKUP));
    ones.salary = 24'hFFFFFE;                // one field off: must miss
    push_item(as_op(ones, FN_LOOKUP));
    ones.salary = 24'hFFFFFF;
    push_item(ones);                         // duplicate goes to the next free slot
    push_item(as_op(ones, FN_LOOKUP));       // first copy wins
    push_item(as_op(ones, FN_UNUSED));
    // same key over and over until the probe walks off the end
    for (int k = 0; k < 7; k++) begin
      chain[k] = fresh_person(FN_INSERT);
      chain[k].years = 6'd5;
      push_item(chain[k]);
    end
    push_item(as_op(chain[3], FN_LOOKUP));
    push_item(as_op(zeros, FN_CLEAR));
    push_item(as_op(ones, FN_LOOKUP));       // gone after clear
  endtask

  // Mostly well-formed insert/lookup traffic against records we know about,
  // with clears, unused func codes, near-miss and unknown lookups as noise
  task automatic run_random(input int unsigned count);
    person_op_t p;
    int unsigned roll;
    int unsigned sel;
    int unsigned flip;
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        p = fresh_person(FN_CLEAR);
        pool.delete();
      end else if (roll < 6) begin
        p = fresh_person(FN_UNUSED);
      end else if (roll < 50) begin
        if (pool.size() != 0 && $urandom_range(0, 3) == 0)
          p = as_op(pool[$urandom_range(0, pool.size() - 1)], FN_INSERT);
        else
          p = fresh_person(FN_INSERT);
        pool = {pool, p};
        if (pool.size() > POOL_MAX) void'(pool.pop_front());
      end else begin
        sel = $urandom_range(0, 99);
        if (pool.size() == 0 || sel >= 85) begin
          p = fresh_person(FN_LOOKUP);
        end else begin
          p = pool[$urandom_range(0, pool.size() - 1)];
          if (sel >= 70) begin
            // flip one record bit (func sits above the record bits)
            flip = $urandom_range(0, PERSON_W - FUNC_W - 1);
            p = p ^ (PERSON_W'(1) << flip);
          end
          p = as_op(p, FN_LOOKUP);
        end
      end
      push_item(p);
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    steady              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.func          = '0;
    in_ch.surname_code  = '0;
    in_ch.post_code     = '0;
    in_ch.birth_day     = '0;
    in_ch.birth_month   = '0;
    in_ch.birth_year    = '0;
    in_ch.service_years = '0;
    in_ch.salary_amount = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // the block runs a clearing pass now; push_item just waits on ready

    run_directed();
    run_random(ITEMS_PER_PHASE);

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      if (ph == PHASES - 1) begin
        phase_size[ph] = $urandom_range(1, 32);
        phase_lin[ph]  = $urandom_range(0, 31);
        phase_sq[ph]   = $urandom_range(1, 31);
      end
      write_settings(phase_size[ph], phase_lin[ph], phase_sq[ph]);
      steady = (ph == STEADY_PHASE);
      run_random(ITEMS_PER_PHASE);
    end
    steady = 1'b0;

    // let everything drain, then watch a bit longer for stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    $display("hash table: %0d results checked over %0d table settings, %0d errors",
             sb.checked, PHASES + 1, sb.errors);
    $display("  cleared %0d, inserted %0d, dropped %0d, found %0d, not found %0d",
             sb.tally[ST_CLEARED], sb.tally[ST_INSERTED], sb.tally[ST_DROPPED],
             sb.tally[ST_FOUND], sb.tally[ST_MISSING]);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
